### src/assert_macros.svh
// Assertion macros used by the top level of the send queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### src/cpsq_pkg.sv
// Types and constants of the coalescing priority send queue.
package cpsq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TAG_BITS    = 16;
   localparam int KEY_BITS    = 8;

   localparam int IDX_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int CAP_BITS = 5;
   localparam int LEN_BITS = 8;
   localparam int LVL_BITS = 2;
   localparam int CMD_BITS = 2;
   localparam int EV_BITS  = 3;
   localparam int LIM_BITS = (CAP_BITS > CNT_BITS) ? CAP_BITS : CNT_BITS;
   localparam int RES_SLOTS = 3;
   localparam int RES_BITS  = 2;

   localparam logic [CAP_BITS-1:0] CAP_RESET    = CAP_BITS'(16);
   localparam logic [LVL_BITS-1:0] SAFETY_LEVEL = LVL_BITS'(2);

   typedef enum logic [CMD_BITS-1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_POP     = 2'd1,
      CMD_CLEAR   = 2'd2
   } cmd_type;

   typedef enum logic [EV_BITS-1:0] {
      EV_ACCEPTED   = 3'd0,
      EV_REJ_EMPTY  = 3'd1,
      EV_REJ_FULL   = 3'd2,
      EV_SUPERSEDED = 3'd3,
      EV_EVICTED    = 3'd4,
      EV_POPPED     = 3'd5,
      EV_CLEARED    = 3'd6
   } event_type;

   typedef struct packed {
      logic [TAG_BITS-1:0] tag;
      logic [LVL_BITS-1:0] level;
      logic [KEY_BITS-1:0] key;
      logic                notify;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_PULL,
      CELL_PUSH,
      CELL_LOAD
   } cell_op_type;

   typedef struct packed {
      logic                found;
      logic [IDX_BITS-1:0] idx;
   } find_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MERGE,
      ST_EVICT,
      ST_INSERT,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      SHIFT_NONE,
      SHIFT_REMOVE,
      SHIFT_INSERT
   } shift_type;

endpackage

### src/cpsq_ifs.sv
// Valid/ready channel interfaces for the command and event streams.
interface cpsq_req_if import cpsq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_BITS-1:0] cmd;
   logic [TAG_BITS-1:0] frame_tag;
   logic [LEN_BITS-1:0] frame_length;
   logic [LVL_BITS-1:0] priority_level;
   logic [KEY_BITS-1:0] merge_key;
   logic                keep_head;
   logic                wants_notify;

   modport source (output valid, cmd, frame_tag, frame_length, priority_level,
                   merge_key, keep_head, wants_notify, input ready);
   modport sink (input valid, cmd, frame_tag, frame_length, priority_level,
                 merge_key, keep_head, wants_notify, output ready);
endinterface

interface cpsq_rsp_if import cpsq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [EV_BITS-1:0]  event_code;
   logic [TAG_BITS-1:0] event_tag;
   logic                head_valid;
   logic [TAG_BITS-1:0] head_tag;
   logic                head_notify;
   logic [CNT_BITS-1:0] occupancy;
   logic                last_result;

   modport source (output valid, event_code, event_tag, head_valid, head_tag,
                   head_notify, occupancy, last_result, input ready);
   modport sink (input valid, event_code, event_tag, head_valid, head_tag,
                 head_notify, occupancy, last_result, output ready);
endinterface

### src/cpsq_cell.sv
// One queue slot: holds an entry and shifts toward either neighbor.
module cpsq_cell import cpsq_pkg::*; (
   input  logic        clock,
   input  cell_op_type op,
   input  entry_type   new_entry,
   input  entry_type   left_entry,
   input  entry_type   right_entry,
   output entry_type   entry
);

   entry_type entry_ff, entry_in;

   always_comb begin
      case (op)
         CELL_PULL: entry_in = right_entry;
         CELL_PUSH: entry_in = left_entry;
         CELL_LOAD: entry_in = new_entry;
         default:   entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

### src/cpsq_find.sv
// Lowest-index set bit of a slot mask.
module cpsq_find import cpsq_pkg::*; (
   input  logic [QUEUE_DEPTH-1:0] mask,
   output find_type               result
);

   always_comb begin
      result.found = |mask;
      result.idx   = '0;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (mask[i]) begin
            result.idx = IDX_BITS'(i);
         end
      end
   end

endmodule

### src/coalescing_priority_send_queue.sv
// Top level of the coalescing priority send queue.
// Usage:
//   req_chan carries commands (enqueue, pop, clear); rsp_chan returns event
//   transactions, one to three per command but none for the unused one,
//   the last flagged by last_result. Each event carries the head entry and
//   occupancy after the whole command. csr_wr_en/csr_wr_data set the capacity.
// Timing:
//   A row of slot cells shifts one step per cycle under a sequencer that does
//   merge, evict and insert as separate states. An enqueue passes through
//   merge, evict, insert and emit before the next command is accepted; pop,
//   clear and a rejected empty frame go from merge straight to emit; the
//   unused command is accepted and dropped in idle. The first event is loaded
//   into the output register in the emit state.
// Reset:
//   Synchronous, active high: queue empty, capacity 16, no event pending.
// Stalls:
//   The final event sits in the output register while the next command is
//   accepted; further events wait in the sequencer until rsp_chan.ready.
`include "assert_macros.svh"

module coalescing_priority_send_queue import cpsq_pkg::*; (
   input logic                clock,
   input logic                reset,
   cpsq_req_if.sink           req_chan,
   cpsq_rsp_if.source         rsp_chan,
   input logic                csr_wr_en,
   input logic [CAP_BITS-1:0] csr_wr_data
);

   state_type state_ff, state_in;
   logic [CAP_BITS-1:0] cap_ff;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic ok_ff, ok_in;
   logic first_ff;

   logic [CMD_BITS-1:0] cmd_ff;
   logic [TAG_BITS-1:0] tag_ff;
   logic                len_zero_ff;
   logic [LVL_BITS-1:0] lvl_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic                notify_ff;

   event_type           res_code_ff [RES_SLOTS];
   logic [TAG_BITS-1:0] res_tag_ff  [RES_SLOTS];
   logic [RES_BITS-1:0] res_cnt_ff;
   logic [RES_BITS-1:0] emit_idx_ff;

   logic                rsp_valid_ff;
   event_type           rsp_code_ff;
   logic [TAG_BITS-1:0] rsp_tag_ff;
   logic                rsp_head_valid_ff;
   logic [TAG_BITS-1:0] rsp_head_tag_ff;
   logic                rsp_head_notify_ff;
   logic [CNT_BITS-1:0] rsp_occ_ff;
   logic                rsp_last_ff;

   entry_type   cell_q  [QUEUE_DEPTH];
   cell_op_type cell_op [QUEUE_DEPTH];
   entry_type   new_entry;

   logic [QUEUE_DEPTH-1:0] key_mask, lvl0_mask, lvl1_mask, ins_mask;
   logic [QUEUE_DEPTH-1:0] victim_mask, find_mask;
   find_type               find_res;

   shift_type           shift_kind;
   logic [IDX_BITS-1:0] shift_idx;
   logic                res_wr;
   event_type           res_wr_code;
   logic [TAG_BITS-1:0] res_wr_tag;

   logic                accept;
   logic                out_load;
   logic                emit_last;
   logic [LIM_BITS-1:0] limit;
   logic                full;

   assign accept    = req_chan.valid && req_chan.ready;
   assign out_load  = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_chan.ready);
   assign emit_last = (emit_idx_ff == res_cnt_ff - RES_BITS'(1));
   assign new_entry = '{tag: tag_ff, level: lvl_ff, key: key_ff, notify: notify_ff};

   // capacity 0 acts as one slot, anything above the depth as the depth
   always_comb begin
      if (cap_ff == '0) begin
         limit = LIM_BITS'(1);
      end else if (LIM_BITS'(cap_ff) > LIM_BITS'(QUEUE_DEPTH)) begin
         limit = LIM_BITS'(QUEUE_DEPTH);
      end else begin
         limit = LIM_BITS'(cap_ff);
      end
   end
   assign full = LIM_BITS'(count_ff) >= limit;

   // slot row
   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      entry_type left_e, right_e;
      if (g == 0) begin : g_first
         assign left_e = cell_q[g];
      end else begin : g_mid
         assign left_e = cell_q[g-1];
      end
      if (g == QUEUE_DEPTH - 1) begin : g_last
         assign right_e = cell_q[g];
      end else begin : g_inner
         assign right_e = cell_q[g+1];
      end
      cpsq_cell u_cell (
         .clock       (clock),
         .op          (cell_op[g]),
         .new_entry   (new_entry),
         .left_entry  (left_e),
         .right_entry (right_e),
         .entry       (cell_q[g])
      );
   end

   // per-slot search masks; the protected head is skipped
   always_comb begin
      logic in_range;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         in_range = ((i != 0) || !first_ff) && (CNT_BITS'(i) < count_ff);
         key_mask[i]  = in_range && (cell_q[i].key == key_ff) && (key_ff != '0);
         lvl0_mask[i] = in_range && (cell_q[i].level == LVL_BITS'(0)) && (lvl_ff != '0);
         lvl1_mask[i] = in_range && (cell_q[i].level == LVL_BITS'(1)) &&
                        (lvl_ff > LVL_BITS'(1)) && (LVL_BITS'(1) < SAFETY_LEVEL);
         ins_mask[i]  = in_range && (cell_q[i].level < lvl_ff);
      end
   end

   assign victim_mask = (|lvl0_mask) ? lvl0_mask : lvl1_mask;

   always_comb begin
      case (state_ff)
         ST_MERGE:  find_mask = key_mask;
         ST_EVICT:  find_mask = victim_mask;
         ST_INSERT: find_mask = ins_mask;
         default:   find_mask = '0;
      endcase
   end

   cpsq_find u_find (
      .mask   (find_mask),
      .result (find_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_chan.cmd)
                  CMD_ENQUEUE, CMD_POP, CMD_CLEAR: state_in = ST_MERGE;
                  default:                         state_in = ST_IDLE;
               endcase
            end
         end
         ST_MERGE: begin
            if ((cmd_ff == CMD_ENQUEUE) && !len_zero_ff) begin
               state_in = ST_EVICT;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EVICT:  state_in = ST_INSERT;
         ST_INSERT: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_load && emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      shift_kind  = SHIFT_NONE;
      shift_idx   = find_res.idx;
      count_in    = count_ff;
      ok_in       = ok_ff;
      res_wr      = 1'b0;
      res_wr_code = EV_ACCEPTED;
      res_wr_tag  = tag_ff;
      case (state_ff)
         ST_IDLE: begin
            ok_in = 1'b1;
         end
         ST_MERGE: begin
            case (cmd_ff)
               CMD_ENQUEUE: begin
                  if (len_zero_ff) begin
                     res_wr      = 1'b1;
                     res_wr_code = EV_REJ_EMPTY;
                  end else if (find_res.found) begin
                     shift_kind  = SHIFT_REMOVE;
                     count_in    = count_ff - CNT_BITS'(1);
                     res_wr      = cell_q[find_res.idx].notify;
                     res_wr_code = EV_SUPERSEDED;
                     res_wr_tag  = cell_q[find_res.idx].tag;
                  end
               end
               CMD_POP: begin
                  res_wr      = 1'b1;
                  res_wr_code = EV_POPPED;
                  res_wr_tag  = '0;
                  if (count_ff != '0) begin
                     shift_kind = SHIFT_REMOVE;
                     shift_idx  = '0;
                     count_in   = count_ff - CNT_BITS'(1);
                     res_wr_tag = cell_q[0].tag;
                  end
               end
               CMD_CLEAR: begin
                  count_in    = '0;
                  res_wr      = 1'b1;
                  res_wr_code = EV_CLEARED;
                  res_wr_tag  = '0;
               end
               default: begin
                  res_wr = 1'b0;
               end
            endcase
         end
         ST_EVICT: begin
            if (full) begin
               if (find_res.found) begin
                  shift_kind  = SHIFT_REMOVE;
                  count_in    = count_ff - CNT_BITS'(1);
                  res_wr      = cell_q[find_res.idx].notify;
                  res_wr_code = EV_EVICTED;
                  res_wr_tag  = cell_q[find_res.idx].tag;
               end else begin
                  ok_in = 1'b0;
               end
            end
         end
         ST_INSERT: begin
            res_wr = 1'b1;
            if (ok_ff) begin
               shift_kind  = SHIFT_INSERT;
               shift_idx   = find_res.found ? find_res.idx : IDX_BITS'(count_ff);
               count_in    = count_ff + CNT_BITS'(1);
               res_wr_code = EV_ACCEPTED;
            end else begin
               res_wr_code = EV_REJ_FULL;
            end
         end
         default: begin
            ok_in = ok_ff;
         end
      endcase
   end

   // translate the shift into per-cell moves
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         case (shift_kind)
            SHIFT_REMOVE: begin
               cell_op[i] = (IDX_BITS'(i) >= shift_idx) ? CELL_PULL : CELL_HOLD;
            end
            SHIFT_INSERT: begin
               if (IDX_BITS'(i) > shift_idx) begin
                  cell_op[i] = CELL_PUSH;
               end else if (IDX_BITS'(i) == shift_idx) begin
                  cell_op[i] = CELL_LOAD;
               end else begin
                  cell_op[i] = CELL_HOLD;
               end
            end
            default: cell_op[i] = CELL_HOLD;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         ok_ff        <= 1'b1;
         res_cnt_ff   <= '0;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ok_ff    <= ok_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (accept) begin
            res_cnt_ff  <= '0;
            emit_idx_ff <= '0;
         end else begin
            if (res_wr) begin
               res_cnt_ff <= res_cnt_ff + RES_BITS'(1);
            end
            if (out_load) begin
               emit_idx_ff <= emit_idx_ff + RES_BITS'(1);
            end
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= req_chan.cmd;
         tag_ff      <= req_chan.frame_tag;
         len_zero_ff <= (req_chan.frame_length == '0);
         lvl_ff      <= req_chan.priority_level;
         key_ff      <= req_chan.merge_key;
         notify_ff   <= req_chan.wants_notify;
         first_ff    <= req_chan.keep_head && (count_ff != '0);
      end
      if (res_wr) begin
         res_code_ff[res_cnt_ff] <= res_wr_code;
         res_tag_ff[res_cnt_ff]  <= res_wr_tag;
      end
      if (out_load) begin
         rsp_code_ff        <= res_code_ff[emit_idx_ff];
         rsp_tag_ff         <= res_tag_ff[emit_idx_ff];
         rsp_head_valid_ff  <= (count_ff != '0);
         rsp_head_tag_ff    <= (count_ff != '0) ? cell_q[0].tag : '0;
         rsp_head_notify_ff <= (count_ff != '0) && cell_q[0].notify;
         rsp_occ_ff         <= count_ff;
         rsp_last_ff        <= emit_last;
      end
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.event_code  = rsp_code_ff;
   assign rsp_chan.event_tag   = rsp_tag_ff;
   assign rsp_chan.head_valid  = rsp_head_valid_ff;
   assign rsp_chan.head_tag    = rsp_head_tag_ff;
   assign rsp_chan.head_notify = rsp_head_notify_ff;
   assign rsp_chan.occupancy   = rsp_occ_ff;
   assign rsp_chan.last_result = rsp_last_ff;

   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, LIM_BITS'(count_ff) <= LIM_BITS'(QUEUE_DEPTH))
   `ASSERT_IMPLIES(a_emit_pending, clock, reset, state_ff == ST_EMIT, emit_idx_ff < res_cnt_ff)
   `ASSERT_NEXT(a_clear_empties, clock, reset, state_ff == ST_MERGE && cmd_ff == CMD_CLEAR, count_ff == '0)
   `ASSERT_IMPLIES(a_head_consistent, clock, reset, rsp_valid_ff, rsp_head_valid_ff == (rsp_occ_ff != '0))

endmodule
